// File: src/sxfp_pkg.sv
// Shared types and constants for the sync/length/XOR frame parser.
// No dependencies; used by the parser core and its payload RAM sizing.
`default_nettype none

package sxfp_pkg;

    localparam int unsigned PAYLOAD_MAX = 64;
    localparam int unsigned STORE_AW    = $clog2(PAYLOAD_MAX);

    localparam logic [7:0]  SYNC_BYTE     = 8'h7E;
    localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

    // input item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] frame_command;
        logic [6:0] frame_length;
        logic [7:0] payload_byte;
        logic [5:0] byte_index;
        logic       last;
    } out_word_t;

endpackage

`default_nettype wire

// File: src/sxfp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module sxfp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/sync_length_xor_frame_parser_core.sv
// Frame parser core: sync hunt, command, length, payload, XOR check, tick timeout.
// Depends on sxfp_pkg and sxfp_ram (payload store).
//
// Usage:
//   rx channel carries one word per received byte (cmd = byte) or per time
//   tick (cmd = tick). tx channel carries result words. A word moves when
//   valid is high and stall is low at a rising edge of clk.
//   cfg_we/cfg_wdata load the timeout register (ticks allowed without a
//   delivered frame); write it only while the block is idle.
// Timing:
//   A word that yields a single result (timeout or empty frame) loads the output
//   register in the cycle it is taken. A good check byte with N payload bytes
//   starts a burst: the payload RAM read of entry 0 goes out with the check
//   byte, then one result per cycle while tx is not stalled, and rx is stalled
//   until the last result is loaded. The registered RAM read sets the pace.
// Reset: rst_n clears the parser to sync hunting, the tick counter to zero
//   and the timeout register to 5000. The payload RAM is not cleared.
// Stall: while tx is stalled with a word held, rx is stalled too; the burst
//   pauses and resumes without losing or repeating a word.
`default_nettype none

module sync_length_xor_frame_parser_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rx_valid,
    output logic                    rx_stall,
    input  wire sxfp_pkg::in_word_t rx_word,
    output logic                    tx_valid,
    input  wire logic               tx_stall,
    output sxfp_pkg::out_word_t     tx_word,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_wdata
);

    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_CMD   = 5'b00010,
        PH_LEN   = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_CHECK = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_BURST = 2'b10
    } ctrl_t;

    localparam int unsigned AW = sxfp_pkg::STORE_AW;

    phase_t               phase_reg, phase_next;
    ctrl_t                ctrl_reg, ctrl_next;
    logic [7:0]           cmd_reg, cmd_next;
    logic [6:0]           len_reg, len_next;
    logic [6:0]           fill_reg, fill_next;
    logic [7:0]           xor_reg, xor_next;
    logic [31:0]          elapsed_reg, elapsed_next;
    logic [31:0]          timeout_reg;
    logic [AW-1:0]        idx_reg, idx_next;
    logic                 tx_valid_reg, tx_valid_next;
    sxfp_pkg::out_word_t  tx_word_reg, tx_word_next;

    logic                 out_free;
    logic                 rx_take;
    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [7:0]           ram_rdata;
    logic [31:0]          elapsed_inc;
    logic [6:0]           fill_inc;
    logic [7:0]           xor_upd;
    logic                 burst_last;

    sxfp_ram #(
        .WIDTH (8),
        .DEPTH (sxfp_pkg::PAYLOAD_MAX)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (rx_word.data_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free    = !tx_valid_reg || !tx_stall;
    assign rx_stall    = (ctrl_reg != S_IDLE) || !out_free;
    assign rx_take     = rx_valid && !rx_stall;
    assign tx_valid    = tx_valid_reg;
    assign tx_word     = tx_word_reg;

    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 32'd1;
    assign fill_inc    = fill_reg + 7'd1;
    assign xor_upd     = xor_reg ^ rx_word.data_byte;
    assign burst_last  = ({1'b0, idx_reg} + 7'd1) == len_reg;

    assign ram_we = rx_take && (rx_word.cmd == sxfp_pkg::KIND_BYTE) && (phase_reg == PH_DATA);

    always_comb
    begin
        phase_next    = phase_reg;
        ctrl_next     = ctrl_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        fill_next     = fill_reg;
        xor_next      = xor_reg;
        elapsed_next  = elapsed_reg;
        idx_next      = idx_reg;
        tx_valid_next = tx_valid_reg && tx_stall;
        tx_word_next  = tx_word_reg;
        ram_raddr     = '0;

        unique case (ctrl_reg)
            S_IDLE:
            begin
                if (rx_take)
                begin
                    if (rx_word.cmd == sxfp_pkg::KIND_TICK)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc > timeout_reg)
                        begin
                            phase_next    = PH_HUNT;
                            elapsed_next  = '0;
                            tx_valid_next = 1'b1;
                            tx_word_next  = '{status: sxfp_pkg::ST_TIMEOUT,
                                              frame_command: '0, frame_length: '0,
                                              payload_byte: '0, byte_index: '0,
                                              last: 1'b1};
                        end
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_CMD:
                            begin
                                cmd_next   = rx_word.data_byte;
                                xor_next   = rx_word.data_byte;
                                phase_next = PH_LEN;
                            end
                            PH_LEN:
                            begin
                                len_next  = rx_word.data_byte[6:0];
                                xor_next  = xor_upd;
                                fill_next = '0;
                                if (rx_word.data_byte > 8'(sxfp_pkg::PAYLOAD_MAX))
                                begin
                                    phase_next = PH_HUNT;
                                end
                                else if (rx_word.data_byte == 8'd0)
                                begin
                                    phase_next = PH_CHECK;
                                end
                                else
                                begin
                                    phase_next = PH_DATA;
                                end
                            end
                            PH_DATA:
                            begin
                                xor_next  = xor_upd;
                                fill_next = fill_inc;
                                if (fill_inc >= len_reg)
                                begin
                                    phase_next = PH_CHECK;
                                end
                            end
                            PH_CHECK:
                            begin
                                phase_next = PH_HUNT;
                                if (rx_word.data_byte == xor_reg)
                                begin
                                    elapsed_next = '0;
                                    if (len_reg == 7'd0)
                                    begin
                                        tx_valid_next = 1'b1;
                                        tx_word_next  = '{status: sxfp_pkg::ST_EMPTY,
                                                          frame_command: cmd_reg,
                                                          frame_length: '0,
                                                          payload_byte: '0,
                                                          byte_index: '0,
                                                          last: 1'b1};
                                    end
                                    else
                                    begin
                                        // RAM read of entry 0 goes out this cycle
                                        ctrl_next = S_BURST;
                                        idx_next  = '0;
                                    end
                                end
                            end
                            PH_HUNT:
                            begin
                                if (rx_word.data_byte == sxfp_pkg::SYNC_BYTE)
                                begin
                                    phase_next = PH_CMD;
                                end
                            end
                            default:
                            begin
                                // unused codes behave as hunting
                                phase_next = PH_HUNT;
                                if (rx_word.data_byte == sxfp_pkg::SYNC_BYTE)
                                begin
                                    phase_next = PH_CMD;
                                end
                            end
                        endcase
                    end
                end
            end
            S_BURST:
            begin
                // ram_rdata holds entry idx_reg; re-read it while tx is blocked
                ram_raddr = idx_reg;
                if (out_free)
                begin
                    tx_valid_next = 1'b1;
                    tx_word_next  = '{status: sxfp_pkg::ST_PAYLOAD,
                                      frame_command: cmd_reg,
                                      frame_length: len_reg,
                                      payload_byte: ram_rdata,
                                      byte_index: idx_reg,
                                      last: burst_last};
                    idx_next  = idx_reg + AW'(1);
                    ram_raddr = idx_reg + AW'(1);
                    if (burst_last)
                    begin
                        ctrl_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                ctrl_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            ctrl_reg     <= S_IDLE;
            elapsed_reg  <= '0;
            timeout_reg  <= sxfp_pkg::TIMEOUT_RESET;
            tx_valid_reg <= 1'b0;
            cmd_reg      <= '0;
            len_reg      <= '0;
            fill_reg     <= '0;
            xor_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            ctrl_reg     <= ctrl_next;
            elapsed_reg  <= elapsed_next;
            tx_valid_reg <= tx_valid_next;
            cmd_reg      <= cmd_next;
            len_reg      <= len_next;
            fill_reg     <= fill_next;
            xor_reg      <= xor_next;
            idx_reg      <= idx_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tx_word_reg <= tx_word_next;
    end

endmodule

`default_nettype wire

// File: tb/sync_length_xor_frame_parser_core_tb.sv
// Self-checking testbench for sync_length_xor_frame_parser_core: directed table, then
// random frames, ticks and noise under several timeout settings, with random stalls.
// Depends on sxfp_pkg and the parser core RTL.
module sync_length_xor_frame_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 3000;   // cycles with no word moving on either side
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int PHASE_ITEMS = 40;
    localparam int NUM_PHASES  = 6;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_CMD   = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4
    } parse_phase_t;

    typedef struct {
        sxfp_pkg::in_word_t  word;
        bit                  typed;
        sxfp_pkg::out_word_t result;
    } directed_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                rx_valid = 1'b0;
    logic                rx_stall;
    sxfp_pkg::in_word_t  rx_word = '0;
    logic                tx_valid;
    logic                tx_stall = 1'b0;
    sxfp_pkg::out_word_t tx_word;
    logic                cfg_we = 1'b0;
    logic [31:0]         cfg_wdata = '0;

    sync_length_xor_frame_parser_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_word   (rx_word),
        .tx_valid  (tx_valid),
        .tx_stall  (tx_stall),
        .tx_word   (tx_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // parser mirror
    parse_phase_t parse_ph = PH_HUNT;
    logic [7:0]   cmd_hold = '0;
    logic [6:0]   len_hold = '0;
    logic [6:0]   fill_pos = '0;
    logic [7:0]   xor_acc = '0;
    logic [7:0]   frame_store [sxfp_pkg::PAYLOAD_MAX];
    logic [31:0]  tick_count = '0;
    logic [31:0]  timeout_reg = sxfp_pkg::TIMEOUT_RESET;

    sxfp_pkg::out_word_t step_results [$];
    sxfp_pkg::out_word_t expected_words [$];
    sxfp_pkg::in_word_t  stim [$];

    int  error_count = 0;
    int  result_count = 0;
    int  quiet_cycles = 0;
    bit  rx_idle_on = 1'b1;
    bit  tx_idle_on = 1'b1;
    bit  hold_request = 1'b0;

    initial begin
        forever #10 clk = ~clk;
    end

    task automatic report_error(input string msg);
        error_count++;
        $display("%0t ns: %s", $realtime, msg);
    endtask

    task automatic clear_parser();
        parse_ph = PH_HUNT;
        cmd_hold = '0;
        len_hold = '0;
        fill_pos = '0;
        xor_acc  = '0;
    endtask

    // Advance the mirror by one word; results land in step_results.
    task automatic parse_word(input sxfp_pkg::in_word_t w);
        logic [7:0]          b;
        logic [7:0]          c;
        logic [6:0]          n;
        sxfp_pkg::out_word_t r;
        b = w.data_byte;
        step_results.delete();
        if (w.cmd == sxfp_pkg::KIND_TICK) begin
            if (tick_count != 32'hFFFF_FFFF)
                tick_count = tick_count + 32'd1;
            if (tick_count > timeout_reg) begin
                clear_parser();
                tick_count = '0;
                r = '0;
                r.status = sxfp_pkg::ST_TIMEOUT;
                r.last = 1'b1;
                step_results.push_back(r);
            end
            return;
        end
        case (parse_ph)
            PH_CMD:
            begin
                cmd_hold = b;
                xor_acc  = b;
                parse_ph = PH_LEN;
            end
            PH_LEN:
            begin
                len_hold = b[6:0];
                xor_acc  = xor_acc ^ b;
                if (b > sxfp_pkg::PAYLOAD_MAX)
                    clear_parser();
                else if (b == 8'd0)
                    parse_ph = PH_CHECK;
                else
                begin
                    fill_pos = '0;
                    parse_ph = PH_DATA;
                end
            end
            PH_DATA:
            begin
                frame_store[fill_pos[5:0]] = b;
                xor_acc  = xor_acc ^ b;
                fill_pos = fill_pos + 7'd1;
                if (fill_pos >= len_hold)
                    parse_ph = PH_CHECK;
            end
            PH_CHECK:
            begin
                if (b == xor_acc) begin
                    n = len_hold;
                    c = cmd_hold;
                    clear_parser();
                    tick_count = '0;
                    if (n == 7'd0) begin
                        r = '0;
                        r.status = sxfp_pkg::ST_EMPTY;
                        r.frame_command = c;
                        r.last = 1'b1;
                        step_results.push_back(r);
                    end
                    else
                    begin
                        for (int i = 0; i < int'(n); i++) begin
                            r.status        = sxfp_pkg::ST_PAYLOAD;
                            r.frame_command = c;
                            r.frame_length  = n;
                            r.payload_byte  = frame_store[i];
                            r.byte_index    = 6'(i);
                            r.last          = (i == int'(n) - 1);
                            step_results.push_back(r);
                        end
                    end
                end
                else
                    clear_parser();
            end
            default:
            begin
                // unused codes fall back to hunting
                parse_ph = (b == sxfp_pkg::SYNC_BYTE) ? PH_CMD : PH_HUNT;
            end
        endcase
    endtask

    // Offer one word after a random gap; on acceptance queue what it should produce.
    task automatic send_word(input sxfp_pkg::in_word_t w, input bit typed,
                             input sxfp_pkg::out_word_t typed_word);
        int gap;
        gap = rx_idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_word  <= w;
        rx_valid <= 1'b1;
        do
            @(posedge clk);
        while (rx_stall !== 1'b0);
        parse_word(w);
        if (typed)
            expected_words.push_back(typed_word);
        else
            foreach (step_results[i])
                expected_words.push_back(step_results[i]);
    endtask

    task automatic wait_drained();
        rx_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        // a word that makes no result may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [31:0] ticks);
        cfg_wdata <= ticks;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        timeout_reg = ticks;
    endtask

    // A data byte with the odd tick slipped in ahead of it.
    task automatic queue_byte(input logic [7:0] b);
        if ($urandom_range(0, 5) == 0)
            stim.push_back('{cmd: sxfp_pkg::KIND_TICK,
                             data_byte: 8'($urandom_range(0, 255))});
        stim.push_back('{cmd: sxfp_pkg::KIND_BYTE, data_byte: b});
    endtask

    task automatic queue_frame(input int force_len);
        int         len;
        int         pick;
        logic [7:0] fcmd;
        logic [7:0] x;
        logic [7:0] chk;
        if (force_len < 0 && $urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 4))
                stim.push_back('{cmd: sxfp_pkg::KIND_BYTE,
                                 data_byte: 8'($urandom_range(0, 255))});
            return;
        end
        pick = $urandom_range(0, 99);
        if (force_len >= 0)
            len = force_len;
        else if (pick < 65)
            len = $urandom_range(0, 8);
        else if (pick < 80)
            len = $urandom_range(9, 63);
        else if (pick < 85)
            len = sxfp_pkg::PAYLOAD_MAX;
        else
            len = $urandom_range(sxfp_pkg::PAYLOAD_MAX + 1, 255);
        fcmd = 8'($urandom_range(0, 255));
        queue_byte(sxfp_pkg::SYNC_BYTE);
        queue_byte(fcmd);
        queue_byte(8'(len));
        if (len > sxfp_pkg::PAYLOAD_MAX)
            return;
        chk = fcmd ^ 8'(len);
        for (int i = 0; i < len; i++) begin
            x = 8'($urandom_range(0, 255));
            chk = chk ^ x;
            queue_byte(x);
        end
        if ($urandom_range(0, 99) < 85)
            queue_byte(chk);
        else
            queue_byte(chk ^ 8'($urandom_range(1, 255)));
    endtask

    function automatic directed_row_t plain_row(logic kind, logic [7:0] b);
        directed_row_t row;
        row.word.cmd       = kind;
        row.word.data_byte = b;
        row.typed          = 1'b0;
        row.result         = '0;
        return row;
    endfunction

    function automatic directed_row_t typed_row(logic kind, logic [7:0] b,
                                                sxfp_pkg::status_t st, logic [7:0] c);
        directed_row_t row;
        row = plain_row(kind, b);
        row.typed                = 1'b1;
        row.result.status        = st;
        row.result.frame_command = c;
        row.result.last          = 1'b1;
        return row;
    endfunction

    // no-progress watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if ((rx_valid && !rx_stall) || (tx_valid && !tx_stall))
                quiet_cycles <= 0;
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("sync_length_xor_frame_parser_core_tb: done, errors");
                    $finish;
                end
            end
        end
    end

    // result side: random stalls, one long hold-off on request, in-order compare
    initial begin
        int                  k;
        sxfp_pkg::out_word_t got;
        sxfp_pkg::out_word_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                k = HOLD_CYCLES;
            end
            else
                k = tx_idle_on ? $urandom_range(0, 18) : 0;
            if (k > 0) begin
                tx_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            tx_stall <= 1'b0;
            do
                @(posedge clk);
            while (tx_valid !== 1'b1);
            got = tx_word;
            result_count++;
            if (result_count % 40 == 0)
                tx_idle_on = $urandom_range(0, 1);
            if (expected_words.size() == 0)
                report_error($sformatf("result %0d: unexpected word %h", result_count, got));
            else
            begin
                want = expected_words.pop_front();
                if (got.status !== want.status)
                    report_error($sformatf("result %0d: status %0d, expected %0d",
                                           result_count, got.status, want.status));
                if (got.frame_command !== want.frame_command)
                    report_error($sformatf("result %0d: frame_command %h, expected %h",
                                           result_count, got.frame_command,
                                           want.frame_command));
                if (got.frame_length !== want.frame_length)
                    report_error($sformatf("result %0d: frame_length %0d, expected %0d",
                                           result_count, got.frame_length,
                                           want.frame_length));
                if (got.payload_byte !== want.payload_byte)
                    report_error($sformatf("result %0d: payload_byte %h, expected %h",
                                           result_count, got.payload_byte,
                                           want.payload_byte));
                if (got.byte_index !== want.byte_index)
                    report_error($sformatf("result %0d: byte_index %0d, expected %0d",
                                           result_count, got.byte_index, want.byte_index));
                if (got.last !== want.last)
                    report_error($sformatf("result %0d: last %b, expected %b",
                                           result_count, got.last, want.last));
            end
        end
    end

    // stimulus side
    initial begin
        directed_row_t       directed_rows [$];
        logic [31:0]         phase_timeouts [NUM_PHASES];
        sxfp_pkg::out_word_t none;
        int                  sent;

        none = '0;
        phase_timeouts[0] = 32'hFFFF_FFFF;  // never times out; used for the hold-off
        phase_timeouts[1] = 32'd0;          // every tick times out
        phase_timeouts[2] = 32'd3;
        phase_timeouts[3] = sxfp_pkg::TIMEOUT_RESET;
        phase_timeouts[4] = 32'd20;
        phase_timeouts[5] = 32'($urandom_range(1, 40));

        directed_rows = '{
            plain_row(sxfp_pkg::KIND_TICK, 8'h00),
            typed_row(sxfp_pkg::KIND_TICK, 8'hFF, sxfp_pkg::ST_TIMEOUT, 8'h00),
            // empty frame, all zero
            plain_row(sxfp_pkg::KIND_BYTE, sxfp_pkg::SYNC_BYTE),
            plain_row(sxfp_pkg::KIND_BYTE, 8'h00),
            plain_row(sxfp_pkg::KIND_BYTE, 8'h00),
            typed_row(sxfp_pkg::KIND_BYTE, 8'h00, sxfp_pkg::ST_EMPTY, 8'h00),
            // one payload byte
            plain_row(sxfp_pkg::KIND_BYTE, sxfp_pkg::SYNC_BYTE),
            plain_row(sxfp_pkg::KIND_BYTE, 8'hFF),
            plain_row(sxfp_pkg::KIND_BYTE, 8'h01),
            plain_row(sxfp_pkg::KIND_BYTE, 8'hFF),
            plain_row(sxfp_pkg::KIND_BYTE, 8'h01),
            // length one above the limit
            plain_row(sxfp_pkg::KIND_BYTE, sxfp_pkg::SYNC_BYTE),
            plain_row(sxfp_pkg::KIND_BYTE, 8'h12),
            plain_row(sxfp_pkg::KIND_BYTE, 8'h41),
            // bad check that is itself a sync byte; must not restart the frame
            plain_row(sxfp_pkg::KIND_BYTE, sxfp_pkg::SYNC_BYTE),
            plain_row(sxfp_pkg::KIND_BYTE, 8'h05),
            plain_row(sxfp_pkg::KIND_BYTE, 8'h00),
            plain_row(sxfp_pkg::KIND_BYTE, sxfp_pkg::SYNC_BYTE),
            // timeout in the middle of a frame
            plain_row(sxfp_pkg::KIND_TICK, 8'h7E),
            plain_row(sxfp_pkg::KIND_BYTE, sxfp_pkg::SYNC_BYTE),
            typed_row(sxfp_pkg::KIND_TICK, 8'h00, sxfp_pkg::ST_TIMEOUT, 8'h00),
            plain_row(sxfp_pkg::KIND_BYTE, 8'h00),
            plain_row(sxfp_pkg::KIND_BYTE, sxfp_pkg::SYNC_BYTE),
            plain_row(sxfp_pkg::KIND_BYTE, 8'hA5),
            plain_row(sxfp_pkg::KIND_BYTE, 8'h00),
            typed_row(sxfp_pkg::KIND_BYTE, 8'hA5, sxfp_pkg::ST_EMPTY, 8'hA5)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_timeout(32'd1);
        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);

        sent = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            set_timeout(phase_timeouts[p]);
            stim.delete();
            // full-size frame first in the no-timeout phase so the hold-off backs it up
            if (p == 0)
                queue_frame(sxfp_pkg::PAYLOAD_MAX);
            while (stim.size() < PHASE_ITEMS)
                queue_frame(-1);
            if (p == 0)
                hold_request = 1'b1;
            foreach (stim[i]) begin
                send_word(stim[i], 1'b0, none);
                sent++;
                if (sent % 50 == 0)
                    rx_idle_on = $urandom_range(0, 1);
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("sync_length_xor_frame_parser_core_tb: done, clean");
        else
            $display("sync_length_xor_frame_parser_core_tb: done, errors");
        $finish;
    end

endmodule

// File: sync_length_xor_frame_parser_core.f
src/sxfp_pkg.sv
src/sxfp_ram.sv
src/sync_length_xor_frame_parser_core.sv
tb/sync_length_xor_frame_parser_core_tb.sv
